// ===== sv/cdq_pkg.sv =====
`timescale 1ns / 1ps

package cdq_pkg;

    localparam int DATA_W        = 32;
    localparam int KIND_W        = 3;
    localparam int CAP_W         = 5;
    localparam int CNT_W         = 5;
    localparam int DEPTH_DEFAULT = 16;

    localparam logic [CAP_W-1:0]  CAP_RESET  = 5'd16;
    localparam logic [DATA_W-1:0] EMPTY_WORD = '1;

    localparam logic [KIND_W-1:0] KIND_INS_FRONT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_INS_REAR  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_DEL_FRONT = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DEL_REAR  = 3'd3;

    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic signed [DATA_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic                     ok;
        logic signed [DATA_W-1:0] front_value;
        logic signed [DATA_W-1:0] rear_value;
        logic                     is_empty;
        logic                     is_full;
        logic [CNT_W-1:0]         occupancy;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic exec;
        logic read;
    } t_dp_cmd;

endpackage

// ===== sv/cdq_ctrl.sv =====
`timescale 1ns / 1ps

module cdq_ctrl
    import cdq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_out_stall,
    output logic    o_in_stall,
    output logic    o_out_valid,
    output t_dp_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_READ = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_READ;
            end
            S_READ: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_cmd.load  = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.exec  = (r_state == S_EXEC);
    assign o_cmd.read  = (r_state == S_READ);

endmodule

// ===== sv/cdq_datapath.sv =====
`timescale 1ns / 1ps

module cdq_datapath
    import cdq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_wdata,
    input  t_dp_cmd          i_cmd,
    input  t_in_item         i_in_item,
    output t_out_item        o_out_item
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CMP_W = ((IDX_W > CAP_W) ? IDX_W : CAP_W) + 1;

    function automatic logic [CAP_W-1:0] clamp_cap(input logic [CAP_W-1:0] raw);
        logic [CAP_W-1:0] v;
        v = raw;
        if (raw == '0) begin
            v = CAP_W'(1);
        end else if (int'(raw) > DEPTH) begin
            v = CAP_W'(DEPTH);
        end
        return v;
    endfunction

    logic [DATA_W-1:0] r_mem [DEPTH];

    t_in_item          r_item;
    logic [CAP_W-1:0]  r_cap;
    logic [IDX_W-1:0]  r_head;
    logic [IDX_W-1:0]  r_tail;
    logic [CNT_W-1:0]  r_count;
    logic              r_ok;
    logic [DATA_W-1:0] r_rd_front;
    logic [DATA_W-1:0] r_rd_rear;

    logic [IDX_W-1:0]  n_head;
    logic [IDX_W-1:0]  n_tail;
    logic [CNT_W-1:0]  n_count;
    logic              n_ok;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [CAP_W-1:0]  cfg_cap;
    logic [CAP_W-1:0]  rst_cap;
    logic              is_full;
    logic              is_empty;
    logic [IDX_W-1:0]  head_up;
    logic [IDX_W-1:0]  head_down;
    logic [IDX_W-1:0]  tail_up;
    logic [IDX_W-1:0]  tail_down;
    logic [IDX_W-1:0]  cap_last;

    assign cfg_cap  = clamp_cap(i_cfg_wdata);
    assign rst_cap  = clamp_cap(CAP_RESET);
    assign is_full  = (r_count >= CNT_W'(r_cap));
    assign is_empty = (r_count == '0);
    assign cap_last = IDX_W'(r_cap - CAP_W'(1));

    assign head_up   = ((CMP_W'(r_head) + CMP_W'(1)) >= CMP_W'(r_cap)) ? '0
                                                                      : r_head + IDX_W'(1);
    assign tail_up   = ((CMP_W'(r_tail) + CMP_W'(1)) >= CMP_W'(r_cap)) ? '0
                                                                      : r_tail + IDX_W'(1);
    assign head_down = (r_head == '0) ? cap_last : r_head - IDX_W'(1);
    assign tail_down = (r_tail == '0) ? cap_last : r_tail - IDX_W'(1);

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        n_ok    = 1'b1;
        wr_en   = 1'b0;
        wr_addr = head_down;
        unique case (r_item.kind)
            KIND_INS_FRONT: begin
                if (is_full) begin
                    n_ok = 1'b0;
                end else begin
                    n_head  = head_down;
                    n_count = r_count + CNT_W'(1);
                    wr_en   = 1'b1;
                    wr_addr = head_down;
                end
            end
            KIND_INS_REAR: begin
                if (is_full) begin
                    n_ok = 1'b0;
                end else begin
                    n_tail  = tail_up;
                    n_count = r_count + CNT_W'(1);
                    wr_en   = 1'b1;
                    wr_addr = tail_up;
                end
            end
            KIND_DEL_FRONT: begin
                if (is_empty) begin
                    n_ok = 1'b0;
                end else begin
                    n_head  = head_up;
                    n_count = r_count - CNT_W'(1);
                end
            end
            KIND_DEL_REAR: begin
                if (is_empty) begin
                    n_ok = 1'b0;
                end else begin
                    n_tail  = tail_down;
                    n_count = r_count - CNT_W'(1);
                end
            end
            default: begin
                n_ok = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= rst_cap;
            r_head  <= '0;
            r_tail  <= IDX_W'(rst_cap - CAP_W'(1));
            r_count <= '0;
        end else if (i_cfg_we) begin
            r_cap   <= cfg_cap;
            r_head  <= '0;
            r_tail  <= IDX_W'(cfg_cap - CAP_W'(1));
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_in_item;
        end
        if (i_cmd.exec) begin
            r_ok <= n_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && wr_en) begin
            r_mem[wr_addr] <= r_item.value;
        end
        if (i_cmd.read) begin
            r_rd_front <= r_mem[r_head];
            r_rd_rear  <= r_mem[r_tail];
        end
    end

    assign o_out_item.ok          = r_ok;
    assign o_out_item.front_value = is_empty ? EMPTY_WORD : r_rd_front;
    assign o_out_item.rear_value  = is_empty ? EMPTY_WORD : r_rd_rear;
    assign o_out_item.is_empty    = is_empty;
    assign o_out_item.is_full     = is_full;
    assign o_out_item.occupancy   = r_count;

endmodule

// ===== sv/circular_deque_core.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake                  Payload
// input     in         i_in_valid / o_in_stall    i_in_item  (t_in_item)
// output    out        o_out_valid / i_out_stall  o_out_item (t_out_item)
// config    in         i_cfg_we                   i_cfg_wdata (capacity)
//
// Each transaction runs these steps in order: accept, index update and store write,
// registered store read of the front and rear entries, and result presentation.
// The result stays on the output until it is taken, and no new input is accepted meanwhile.
// Synchronous active-low reset empties the deque and sets capacity to min(16, DEPTH).
// A capacity write empties the deque in the cycle it is taken.

module circular_deque_core
    import cdq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_wdata,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_item         i_in_item,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_item        o_out_item
);

    t_dp_cmd cmd;

    cdq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    cdq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .i_in_item   (i_in_item),
        .o_out_item  (o_out_item)
    );

`ifndef SYNTHESIS
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.load, cmd.exec, cmd.read}))
        else $error("datapath commands overlap");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (o_in_stall && !o_out_valid))
        else $error("controller not busy after accepting a transaction");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.is_empty) |->
            (o_out_item.occupancy == '0 && o_out_item.front_value == EMPTY_WORD
             && o_out_item.rear_value == EMPTY_WORD && !o_out_item.is_full))
        else $error("inconsistent empty result");
`endif

endmodule
